[src/g711sm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// G.711 sample mixer package
// Companding law code and the fixed constants of mu-law and A-law.
// ----------------------------------------------------------------------------
package g711sm_pkg;

	typedef enum logic {
		LAW_MU = 1'b0,
		LAW_A  = 1'b1
	} law_t;

	// Mu-law constants
	localparam logic [7:0]  MuBias     = 8'h84;
	localparam logic [13:0] MuClip     = 14'd8159;
	localparam logic [13:0] MuBiasQ    = 14'd33;
	localparam logic [7:0]  MuPosMask  = 8'hFF;
	localparam logic [7:0]  MuNegMask  = 8'h7F;
	localparam logic [7:0]  MuOverCode = 8'h7F;

	// A-law constants
	localparam logic [7:0]  AXor       = 8'h55;
	localparam logic [7:0]  APosMask   = 8'hD5;
	localparam logic [8:0]  ASeg1Add   = 9'h108;
	localparam logic [8:0]  ASeg0Add   = 9'h008;

endpackage
`default_nettype wire

[src/g711sm_expand.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// G.711 expander
// Turns one companded byte into a signed linear sample, mu-law or A-law.
// ----------------------------------------------------------------------------
module g711sm_expand (
	input  var g711sm_pkg::law_t law,
	input  wire logic [7:0]         code,
	output logic signed [15:0]      lin
);

	logic [7:0]  mu_u;
	logic [7:0]  mu_t;
	logic [14:0] mu_shifted;
	logic [14:0] mu_mag;

	logic [7:0]  a_v;
	logic [2:0]  a_seg;
	logic [8:0]  a_t;
	logic [14:0] a_mag;

	logic [14:0] mag;
	logic        neg;

	always_comb begin
		mu_u       = ~code;
		mu_t       = {1'b0, mu_u[3:0], 3'b000} + g711sm_pkg::MuBias;
		mu_shifted = 15'(mu_t) << mu_u[6:4];
		mu_mag     = mu_shifted - 15'(g711sm_pkg::MuBias);

		a_v   = code ^ g711sm_pkg::AXor;
		a_seg = a_v[6:4];
		a_t   = {1'b0, a_v[3:0], 4'b0000};
		priority if (a_seg == 3'd0) begin
			a_mag = 15'(a_t + g711sm_pkg::ASeg0Add);
		end else if (a_seg == 3'd1) begin
			a_mag = 15'(a_t + g711sm_pkg::ASeg1Add);
		end else begin
			a_mag = 15'(a_t + g711sm_pkg::ASeg1Add) << (a_seg - 3'd1);
		end

		unique case (law)
			g711sm_pkg::LAW_MU: begin
				mag = mu_mag;
				neg = mu_u[7];
			end
			g711sm_pkg::LAW_A: begin
				mag = a_mag;
				neg = ~a_v[7];
			end
			default: begin
				mag = mu_mag;
				neg = mu_u[7];
			end
		endcase

		lin = neg ? $signed(16'd0 - {1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule
`default_nettype wire

[src/g711sm_compress.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// G.711 compressor
// Turns one signed linear sample into a companded byte, mu-law or A-law.
// ----------------------------------------------------------------------------
module g711sm_compress (
	input  var g711sm_pkg::law_t law,
	input  wire logic signed [15:0] lin,
	output logic [7:0]              code
);

	logic        neg;
	logic [15:0] mu_abs;
	logic [13:0] mu_q;
	logic [13:0] mu_b;
	logic [3:0]  mu_seg;
	logic [3:0]  mu_mant;
	logic [7:0]  mu_code;

	logic [14:0] a_abs;
	logic [11:0] a_q;
	logic [2:0]  a_seg;
	logic [7:0]  a_raw;
	logic [7:0]  a_code;

	always_comb begin
		neg = lin[15];

		// Mu-law: magnitude, quarter scale, clamp, bias, then segment search.
		mu_abs = neg ? (~lin + 16'd1) : lin;
		mu_q   = mu_abs[15:2];
		if (mu_q > g711sm_pkg::MuClip) begin
			mu_q = g711sm_pkg::MuClip;
		end
		mu_b = mu_q + g711sm_pkg::MuBiasQ;
		priority if (mu_b[13]) mu_seg = 4'd8;
		else if (mu_b[12])     mu_seg = 4'd7;
		else if (mu_b[11])     mu_seg = 4'd6;
		else if (mu_b[10])     mu_seg = 4'd5;
		else if (mu_b[9])      mu_seg = 4'd4;
		else if (mu_b[8])      mu_seg = 4'd3;
		else if (mu_b[7])      mu_seg = 4'd2;
		else if (mu_b[6])      mu_seg = 4'd1;
		else                   mu_seg = 4'd0;
		mu_mant = 4'(mu_b >> (mu_seg + 4'd1));
		if (mu_seg == 4'd8) begin
			mu_code = g711sm_pkg::MuOverCode;
		end else begin
			mu_code = {mu_seg[3:0] == 4'd8 ? 4'd0 : mu_seg, mu_mant};
		end
		mu_code = mu_code ^ (neg ? g711sm_pkg::MuNegMask : g711sm_pkg::MuPosMask);

		// A-law: a negative value maps to its ones' complement before scaling.
		a_abs = neg ? ~lin[14:0] : lin[14:0];
		a_q   = a_abs[14:3];
		priority if (a_q[11]) a_seg = 3'd6;
		else if (a_q[10])     a_seg = 3'd5;
		else if (a_q[9])      a_seg = 3'd4;
		else if (a_q[8])      a_seg = 3'd3;
		else if (a_q[7])      a_seg = 3'd2;
		else if (a_q[6])      a_seg = 3'd1;
		else                  a_seg = 3'd0;
		if (a_q < 12'h020) begin
			a_raw = {4'd0, a_q[4:1]};
		end else begin
			a_raw = {1'b0, a_seg + 3'd1, 4'(a_q >> (a_seg + 3'd1))};
		end
		a_code = a_raw ^ (neg ? g711sm_pkg::AXor : g711sm_pkg::APosMask);

		unique case (law)
			g711sm_pkg::LAW_MU: code = mu_code;
			g711sm_pkg::LAW_A:  code = a_code;
			default:            code = mu_code;
		endcase
	end

endmodule
`default_nettype wire

[src/g711_sample_mixer.sv]
`default_nettype none
// Input and result registers form a two-stage pipeline; an item waits in the
// first, its mixed byte in the second. It takes one item per cycle unless the
// output stalls, ready if the first is empty or the second is free or taken.
// Reset: asynchronous, active low; clears both valid bits and selects mu-law.
// ----------------------------------------------------------------------------
// G.711 sample mixer
// Expands a companded byte, adds a linear tone sample with saturation and
// compresses the sum again in the selected law.
// ----------------------------------------------------------------------------
module g711_sample_mixer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         payload_byte,
	input  wire logic signed [15:0] tone_sample,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              mixed_byte
);

	g711sm_pkg::law_t law_q;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic signed [15:0] tone_s1;
	logic               valid_s2;
	logic [7:0]         mixed_s2;

	logic               adv_s1;
	logic signed [15:0] lin;
	logic signed [16:0] sum;
	logic signed [15:0] sat;
	logic [7:0]         code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			law_q <= g711sm_pkg::LAW_MU;
		end else if (cfg_we) begin
			law_q <= g711sm_pkg::law_t'(cfg_wdata[0]);
		end
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= payload_byte;
			tone_s1 <= tone_sample;
		end
		if (adv_s1) begin
			mixed_s2 <= code;
		end
	end

	g711sm_expand u_expand (
		.law  (law_q),
		.code (byte_s1),
		.lin  (lin)
	);

	// The sum carries one extra bit, so overflow shows as a sign mismatch.
	always_comb begin
		sum = 17'(lin) + 17'(tone_s1);
		if (sum[16] != sum[15]) begin
			sat = sum[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			sat = sum[15:0];
		end
	end

	g711sm_compress u_compress (
		.law  (law_q),
		.lin  (sat),
		.code (code)
	);

	assign out_valid  = valid_s2;
	assign mixed_byte = mixed_s2;

`ifndef SYNTHESIS
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_advance_offers: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("advanced item was not offered as a result");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while the pipeline is full and stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input not ready although the input register is empty");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && $stable(byte_s1))
		else $error("stalled item lost from the input register");
`endif

endmodule
`default_nettype wire

[bench/g711_sample_mixer_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// G.711 sample mixer regression
// Drives companded bytes and tone samples through the mixer under both laws,
// predicts every mixed byte in the bench and checks the results in order,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module g711_sample_mixer_test;

	typedef struct packed {
		logic [7:0]         payload;
		logic signed [15:0] tone;
	} sample_pair_t;

	localparam int         MuBiasLin = 132;
	localparam int         MuClipMag = 8159;
	localparam logic [7:0] MuNegCode = 8'h7F;
	localparam logic [7:0] MuSatCode = 8'h7F;
	localparam logic [7:0] AXorCode  = 8'h55;
	localparam logic [7:0] APosCode  = 8'hD5;
	localparam int         ASeg0Base = 8;
	localparam int         ASeg1Base = 264;
	localparam int         AClipMag  = 4095;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_wdata = 1'b0;
	logic               in_valid = 1'b0;
	logic [7:0]         payload_byte = 8'h00;
	logic signed [15:0] tone_sample = 16'sh0000;
	logic               out_ready = 1'b0;
	wire logic          in_ready;
	wire logic          out_valid;
	wire logic [7:0]    mixed_byte;

	sample_pair_t        sample_queue[$];
	logic [7:0]          mixed_bytes_due[$];
	g711sm_pkg::law_t    active_law = g711sm_pkg::LAW_MU;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  hold_off_left = 0;
	int                  mismatches = 0;

	g711_sample_mixer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.tone_sample  (tone_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_byte   (mixed_byte)
	);

	// Expand, add with saturation and compress again in the same law.
	function automatic logic [7:0] mix_sample(g711sm_pkg::law_t law, logic [7:0] payload,
			logic signed [15:0] tone);
		logic [7:0] u;
		logic [7:0] mask;
		logic [7:0] code;
		int lin;
		int seg;
		int mag;
		int v;
		if (law == g711sm_pkg::LAW_MU) begin
			u = ~payload;
			lin = ((int'(u[3:0]) << 3) + MuBiasLin) << u[6:4];
			lin = u[7] ? MuBiasLin - lin : lin - MuBiasLin;
		end else begin
			u = payload ^ AXorCode;
			lin = int'(u[3:0]) << 4;
			seg = int'(u[6:4]);
			if (seg == 0)
				lin = lin + ASeg0Base;
			else if (seg == 1)
				lin = lin + ASeg1Base;
			else
				lin = (lin + ASeg1Base) << (seg - 1);
			if (!u[7])
				lin = -lin;
		end
		lin = lin + int'(tone);
		if (lin > 32767)
			lin = 32767;
		else if (lin < -32768)
			lin = -32768;
		seg = 0;
		if (law == g711sm_pkg::LAW_MU) begin
			mask = (lin < 0) ? MuNegCode : 8'hFF;
			mag = (lin < 0) ? -lin : lin;
			mag = mag >> 2;
			if (mag > MuClipMag)
				mag = MuClipMag;
			mag = mag + (MuBiasLin >> 2);
			for (v = mag >> 6; v > 0 && seg < 8; v = v >> 1)
				seg++;
			if (seg >= 8)
				code = MuSatCode;
			else
				code = 8'((seg << 4) | ((mag >> (seg + 1)) & 15));
		end else begin
			// Negative values are folded to -value-1 before the shift.
			mask = (lin < 0) ? AXorCode : APosCode;
			mag = (lin < 0) ? -lin - 1 : lin;
			mag = mag >> 3;
			if (mag > AClipMag)
				mag = AClipMag;
			if (mag < 32) begin
				code = 8'(mag >> 1);
			end else begin
				for (v = mag >> 5; v > 1 && seg < 7; v = v >> 1)
					seg++;
				code = 8'(((seg + 1) << 4) | ((mag >> (seg + 1)) & 15));
			end
		end
		return code ^ mask;
	endfunction

	function automatic sample_pair_t random_pair();
		sample_pair_t p;
		p.payload = 8'($urandom_range(255));
		case ($urandom_range(3))
			0, 1: begin
				p.tone = 16'($urandom_range(65535));
			end
			2: begin
				p.tone = 16'($urandom_range(2047) - 1024);
			end
			default: begin
				// Near either rail, so that the sum often saturates.
				if ($urandom_range(1))
					p.tone = 16'(16'h7FFF - $urandom_range(255));
				else
					p.tone = 16'(16'h8000 + $urandom_range(255));
			end
		endcase
		return p;
	endfunction

	// Appends one item to the tail of the pending queue.
	task automatic add_pair(logic [7:0] payload, logic [15:0] tone);
		sample_pair_t p;
		p.payload = payload;
		p.tone = tone;
		sample_queue.insert(sample_queue.size(), p);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin : drive_samples
		sample_pair_t next_pair;
		if (arst_n) begin
			if (in_valid && in_ready)
				mixed_bytes_due.insert(mixed_bytes_due.size(),
					mix_sample(active_law, payload_byte, tone_sample));
			if (!in_valid || in_ready) begin
				if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pair = sample_queue.pop_front();
					in_valid <= 1'b1;
					payload_byte <= next_pair.payload;
					tone_sample <= next_pair.tone;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_mixed_bytes
		logic [7:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (mixed_bytes_due.size() == 0) begin
					$display("%0t: mixed_byte expected none, got %02h", $time, mixed_byte);
					mismatches++;
				end else begin
					want = mixed_bytes_due.pop_front();
					if (mixed_byte !== want) begin
						$display("%0t: mixed_byte expected %02h, got %02h", $time, want,
							mixed_byte);
						mismatches++;
					end
				end
			end
			if (hold_off_left > 0) begin
				out_ready <= 1'b0;
				hold_off_left <= hold_off_left - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic wait_drained();
		while (sample_queue.size() > 0 || in_valid || mixed_bytes_due.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The block is idle here, so the new law applies to every later item.
	task automatic write_law(g711sm_pkg::law_t law);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= law;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_law = law;
		@(negedge clk);
	endtask

	task automatic queue_random(int count);
		sample_pair_t p;
		for (int k = 0; k < count; k++) begin
			p = random_pair();
			add_pair(p.payload, p.tone);
		end
	endtask

	// Zero, both rails, saturating sums and the codes around the sign bit.
	task automatic queue_corners();
		add_pair(8'h00, 16'h0000);
		add_pair(8'hFF, 16'h0000);
		add_pair(8'h7F, 16'h0000);
		add_pair(8'h80, 16'h7FFF);
		add_pair(8'h00, 16'h8000);
		add_pair(8'h80, 16'h8000);
		add_pair(8'h00, 16'h7FFF);
		add_pair(8'hFF, 16'h7FFF);
		add_pair(8'hFF, 16'h8000);
		add_pair(8'h55, 16'h0000);
		add_pair(8'hD5, 16'h0001);
		add_pair(8'h2A, 16'hFFFF);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 29;
		recv_idle_pct = 54;
		write_law(g711sm_pkg::LAW_MU);
		queue_corners();
		wait_drained();
		write_law(g711sm_pkg::LAW_A);
		queue_corners();
		wait_drained();

		queue_random(350);
		wait_drained();

		send_idle_pct = 54;
		recv_idle_pct = 29;
		write_law(g711sm_pkg::LAW_MU);
		queue_random(350);
		wait_drained();

		// The output stalls while items keep coming, so the input must back up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_law(g711sm_pkg::LAW_A);
		hold_off_left = 150;
		queue_random(60);
		wait_drained();

		write_law(g711sm_pkg::LAW_MU);
		queue_random(300);
		wait_drained();

		if (mismatches == 0)
			$display("g711_sample_mixer regression: pass");
		else
			$display("g711_sample_mixer regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("g711_sample_mixer regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
src/g711sm_pkg.sv
src/g711sm_expand.sv
src/g711sm_compress.sv
src/g711_sample_mixer.sv
bench/g711_sample_mixer_test.sv
